FILE: design/strm_pkg.sv
// Package for the sparse-table range-minimum block: shared types and constants.
// No dependencies.
package strm_pkg;

  localparam int unsigned MaxElements = 1024;
  localparam int unsigned Levels      = 11;
  localparam int unsigned ValueBits   = 32;
  localparam int unsigned IdxW        = 10;
  localparam int unsigned OutValW     = 32;

  localparam logic [1:0] KindLoad   = 2'd0;
  localparam logic [1:0] KindQuery  = 2'd1;
  localparam logic [1:0] KindClear  = 2'd2;
  localparam logic [1:0] KindUnused = 2'd3;

  typedef enum logic [1:0] {
    OpLoad  = 2'd0,
    OpQuery = 2'd1,
    OpClear = 2'd2,
    OpError = 2'd3
  } op_e;

  // Classified command handed from front to back.
  typedef struct packed {
    op_e              op;
    logic [63:0]      value;
    logic [IdxW-1:0]  lo;
    logic [IdxW-1:0]  hi;
    logic [4:0]       lvl;
  } cmd_t;

endpackage

FILE: design/strm_front.sv
// Front end: accepts transactions, orders query bounds, checks range, picks level.
// Depends on strm_pkg; sits ahead of the command queue.
module strm_front #(
  parameter int unsigned MaxElements = strm_pkg::MaxElements,
  parameter int unsigned Levels      = strm_pkg::Levels,
  parameter int unsigned CntW        = $clog2(MaxElements + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [1:0]            kind_i,
  input  logic [31:0]           value_i,
  input  logic [9:0]            left_i,
  input  logic [9:0]            right_i,
  output logic                  cmd_valid_o,
  output strm_pkg::cmd_t        cmd_o,
  input  logic                  cmd_full_i
);

  logic [CntW-1:0] count_q, count_d;
  logic            take;
  logic [9:0]      lo, hi, len;
  logic [4:0]      k;

  assign full_o = cmd_full_i;
  assign take   = push_i && !cmd_full_i;

  always_comb begin
    lo  = (left_i > right_i) ? right_i : left_i;
    hi  = (left_i > right_i) ? left_i : right_i;
    len = hi - lo;  // len + 1 is range length; floor_log2(len+1)
    k = 5'd0;
    for (int i = 1; i <= 10; i++) begin
      if (({1'b0, len} + 11'd1) >> i != 11'd0) k = 5'(i);
    end
    if (k > 5'(Levels - 1)) k = 5'(Levels - 1);
  end

  always_comb begin
    count_d     = count_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.value = {32'd0, value_i};
    cmd_o.lo    = lo;
    cmd_o.hi    = hi;
    cmd_o.lvl   = k;
    if (take) begin
      case (kind_i)
        strm_pkg::KindLoad: begin
          cmd_valid_o = 1'b1;
          if (count_q >= CntW'(MaxElements)) begin
            cmd_o.op = strm_pkg::OpError;
          end else begin
            cmd_o.op = strm_pkg::OpLoad;
            cmd_o.lo = 10'(count_q);
            count_d  = count_q + CntW'(1);
          end
        end
        strm_pkg::KindQuery: begin
          cmd_valid_o = 1'b1;
          cmd_o.op = (CntW'(hi) >= count_q) ? strm_pkg::OpError : strm_pkg::OpQuery;
        end
        strm_pkg::KindClear: count_d = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

FILE: design/strm_queue.sv
// Short command queue between front and back ends.
// Depends on strm_pkg.
module strm_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  strm_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           rd_i,
  output logic           empty_o,
  output strm_pkg::cmd_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  strm_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i && !full_o) wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + PtrW'(1);
      if (rd_i && !empty_o) rp_q <= (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(wr_i && !full_o) - (PtrW+1)'(rd_i && !empty_o);
    end
  end

endmodule

FILE: design/strm_back.sv
// Back end: holds element store and argmin table, runs load updates and queries, returns error results.
// Depends on strm_pkg; fed by strm_queue.
module strm_back #(
  parameter int unsigned MaxElements = strm_pkg::MaxElements,
  parameter int unsigned Levels      = strm_pkg::Levels,
  parameter int unsigned ValueBits   = strm_pkg::ValueBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_empty_i,
  input  strm_pkg::cmd_t        cmd_i,
  output logic                  cmd_pop_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output logic [9:0]            min_index_o,
  output logic [31:0]           min_value_o,
  output logic                  error_o
);

  localparam int unsigned AW   = $clog2(MaxElements);
  localparam int unsigned LW   = $clog2(Levels);
  localparam int unsigned TabD = MaxElements * Levels;
  localparam int unsigned TW   = $clog2(TabD);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StRdTab = 7'b0000010,
    StWtTab = 7'b0000100,
    StRdVal = 7'b0001000,
    StWtVal = 7'b0010000,
    StCmp   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  logic [ValueBits-1:0] elem_mem [MaxElements];
  logic [9:0]           tab_mem  [TabD];

  state_e             st_q;
  strm_pkg::cmd_t     cmd_q;
  logic [LW-1:0]      lvl_q;
  logic [9:0]         ia_q, ib_q;
  logic [ValueBits-1:0] va_q, vb_q;
  logic [9:0]         tab_rd_q, tab_rd2_q;
  logic [ValueBits-1:0] el_rd_q, el_rd2_q;
  logic               out_v_q;
  logic [9:0]         out_idx_q;
  logic [31:0]        out_val_q;
  logic               out_err_q;

  // Table/element address helpers.
  logic [TW-1:0]      ta_a, ta_b, ta_w;
  logic [AW-1:0]      ea_a, ea_b;
  logic               tab_we, el_we;
  logic [9:0]         tab_wd;
  logic [10:0]        span, s;
  logic               is_load;

  assign is_load = (cmd_q.op == strm_pkg::OpLoad);
  assign span    = 11'd1 << lvl_q;
  // Load: window of 2^lvl ending at position; query: right window start.
  assign s       = is_load ? ({1'b0, cmd_q.lo} + 11'd1 - span)
                           : ({1'b0, cmd_q.hi} + 11'd1 - span);

  always_comb begin
    if (is_load) begin
      ta_a = TW'(s * Levels + 11'(lvl_q) - 11'd1);
      ta_b = TW'((s + (span >> 1)) * Levels + 11'(lvl_q) - 11'd1);
    end else begin
      ta_a = TW'(cmd_q.lo * Levels + 10'(lvl_q));
      ta_b = TW'(s * Levels + 11'(lvl_q));
    end
    ta_w = TW'(s * Levels + 11'(lvl_q));
  end

  assign ea_a = AW'(tab_rd_q);
  assign ea_b = AW'(tab_rd2_q);

  // Two read ports on table and store, registered.
  always_ff @(posedge clk_i) begin
    tab_rd_q  <= tab_mem[ta_a];
    tab_rd2_q <= tab_mem[ta_b];
    el_rd_q   <= elem_mem[ea_a];
    el_rd2_q  <= elem_mem[ea_b];
    if (tab_we) tab_mem[ta_w] <= tab_wd;
    if (el_we)  elem_mem[AW'(cmd_q.lo)] <= ValueBits'(cmd_q.value);
  end

  logic more;
  assign more = (lvl_q < LW'(Levels - 1)) &&
                ((11'd2 << lvl_q) <= ({1'b0, cmd_q.lo} + 11'd1));

  always_comb begin
    tab_we = 1'b0;
    el_we  = 1'b0;
    tab_wd = ia_q;
    if (st_q == StIdle && !cmd_empty_i && !out_v_q) begin
      tab_we = 1'b0;
    end
    if (st_q == StCmp && is_load) begin
      // On a tie the right half's index wins.
      tab_we = 1'b1;
      tab_wd = (el_rd_q < el_rd2_q) ? ia_q : ib_q;
    end
    if (st_q == StRdTab && is_load && lvl_q == '0) begin
      tab_we = 1'b1;
      el_we  = 1'b1;
      tab_wd = cmd_q.lo;
    end
  end

  assign cmd_pop_o   = (st_q == StIdle) && !cmd_empty_i && !out_v_q;
  assign empty_o     = !out_v_q;
  assign min_index_o = out_idx_q;
  assign min_value_o = out_val_q;
  assign error_o     = out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      out_v_q <= 1'b0;
      lvl_q   <= '0;
    end else begin
      if (out_v_q && pop_i) out_v_q <= 1'b0;
      case (st_q)
        StIdle: begin
          if (cmd_pop_o) begin
            cmd_q <= cmd_i;
            lvl_q <= (cmd_i.op == strm_pkg::OpQuery) ? LW'(cmd_i.lvl) : '0;
            case (cmd_i.op)
              strm_pkg::OpError: begin
                out_v_q   <= 1'b1;
                out_idx_q <= '0;
                out_val_q <= '0;
                out_err_q <= 1'b1;
              end
              strm_pkg::OpLoad, strm_pkg::OpQuery: st_q <= StRdTab;
              default: ;
            endcase
          end
        end
        StRdTab: begin
          if (is_load && lvl_q == '0) begin
            if (more) lvl_q <= lvl_q + LW'(1);
            st_q <= more ? StRdTab : StIdle;
          end else begin
            st_q <= StWtTab;
          end
        end
        StWtTab: st_q <= StRdVal;
        StRdVal: begin
          ia_q <= tab_rd_q;
          ib_q <= tab_rd2_q;
          st_q <= StWtVal;
        end
        StWtVal: st_q <= StCmp;
        StCmp: begin
          va_q <= el_rd_q;
          vb_q <= el_rd2_q;
          st_q <= StOut;
        end
        StOut: begin
          if (is_load) begin
            if (more) begin
              lvl_q <= lvl_q + LW'(1);
              st_q  <= StRdTab;
            end else begin
              st_q <= StIdle;
            end
          end else begin
            out_v_q   <= 1'b1;
            out_err_q <= 1'b0;
            if (vb_q < va_q) begin
              out_idx_q <= ib_q;
              out_val_q <= 32'(vb_q);
            end else begin
              out_idx_q <= ia_q;
              out_val_q <= 32'(va_q);
            end
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

endmodule

FILE: design/sparse_table_range_min.sv
// Top level of the sparse-table range-minimum block.
// Depends on strm_pkg, strm_front, strm_queue, strm_back.
//
// Usage:
//   Input channel: drive kind_i/value_i/left_i/right_i with push_i; a
//   transaction is taken when push_i is high and full_o is low.
//   Result channel: while empty_o is low, min_index_o/min_value_o/error_o
//   hold the oldest result; pop_i takes it.
//   A load appends a value, writes its level-0 entry, then rebuilds one
//   entry per higher level (read, wait, read, wait, compare and write),
//   L levels in all, L = min(LEVELS, floor(log2(position + 1)) + 1).
//   With the back end idle, a query passes the queue, then StIdle,
//   StRdTab, StWtTab, StRdVal, StWtVal, StCmp and StOut, which registers
//   its result; an error result is registered in StIdle as it is popped.
//   Clears use no back-end time; the back end pops only when in StIdle.
//   The front end keeps the loaded count and classifies each load and query
//   into a two-entry command queue, so it keeps accepting while the back
//   end works. When the receiver stalls, one result is held and the back
//   end waits; the queue fills and full_o rises.
//   Reset empties the queue and the table (loaded count zero); the
//   element and table memories are not cleared.
module sparse_table_range_min #(
  parameter int unsigned MaxElements = strm_pkg::MaxElements,
  parameter int unsigned Levels      = strm_pkg::Levels,
  parameter int unsigned ValueBits   = strm_pkg::ValueBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] value_i,
  input  logic [9:0]  left_i,
  input  logic [9:0]  right_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [9:0]  min_index_o,
  output logic [31:0] min_value_o,
  output logic        error_o
);

  strm_pkg::cmd_t fcmd, bcmd;
  logic fvalid, qfull, qempty, qpop;

  strm_front #(.MaxElements(MaxElements), .Levels(Levels)) u_front (
    .clk_i, .rst_ni, .push_i, .full_o, .kind_i, .value_i, .left_i, .right_i,
    .cmd_valid_o(fvalid), .cmd_o(fcmd), .cmd_full_i(qfull)
  );

  strm_queue #(.Depth(2)) u_queue (
    .clk_i, .rst_ni, .wr_i(fvalid), .wdata_i(fcmd), .full_o(qfull),
    .rd_i(qpop), .empty_o(qempty), .rdata_o(bcmd)
  );

  strm_back #(.MaxElements(MaxElements), .Levels(Levels), .ValueBits(ValueBits)) u_back (
    .clk_i, .rst_ni, .cmd_empty_i(qempty), .cmd_i(bcmd), .cmd_pop_o(qpop),
    .empty_o, .pop_i, .min_index_o, .min_value_o, .error_o
  );

endmodule

FILE: dv/sparse_table_range_min_checker.sv
// Checker for the sparse-table range-minimum block: watches the input and result channels,
// predicts results and compares them. Depends on strm_pkg.
`timescale 1ns / 1ps

module sparse_table_range_min_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] value_i,
  input  logic [9:0]  left_i,
  input  logic [9:0]  right_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [9:0]  min_index_i,
  input  logic [31:0] min_value_i,
  input  logic        error_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [9:0]  idx;
    logic [31:0] val;
    logic        err;
  } range_result_t;

  logic [31:0]   elems [strm_pkg::MaxElements];
  logic [9:0]    argmin [strm_pkg::MaxElements][strm_pkg::Levels];
  int unsigned   count;
  range_result_t pending_min_q [$];

  function automatic int unsigned floor_log2(int unsigned len);
    int unsigned k;
    k = 0;
    while ((len >> (k + 1)) != 0) k++;
    return k;
  endfunction

  // Append one value and refresh every window ending at it.
  task automatic append_value(logic [31:0] v);
    int unsigned p, s, span;
    logic [9:0] li, ri;
    p = count;
    elems[p[9:0]] = v;
    argmin[p[9:0]][4'd0] = p[9:0];
    for (int j = 1; j < strm_pkg::Levels; j++) begin
      span = 32'd1 << j;
      if (span > p + 1) break;
      s = p + 1 - span;
      li = argmin[s[9:0]][4'(j - 1)];
      ri = argmin[10'(s + span / 2)][4'(j - 1)];
      argmin[s[9:0]][4'(j)] = (elems[li] < elems[ri]) ? li : ri;
    end
    count = p + 1;
  endtask

  task automatic predict_min(logic [1:0] kind, logic [31:0] v, logic [9:0] l, logic [9:0] r);
    range_result_t res;
    int unsigned lo, hi, k;
    logic [9:0] a, b;
    res = '0;
    res.err = 1'b1;
    if (kind == strm_pkg::KindLoad) begin
      if (count >= strm_pkg::MaxElements) pending_min_q.push_back(res);
      else append_value(v);
    end else if (kind == strm_pkg::KindQuery) begin
      lo = 32'((l > r) ? r : l);
      hi = 32'((l > r) ? l : r);
      if (hi < count) begin
        k = floor_log2(hi - lo + 1);
        if (k > strm_pkg::Levels - 1) k = strm_pkg::Levels - 1;
        a = argmin[lo[9:0]][k[3:0]];
        b = argmin[10'(hi + 1 - (32'd1 << k))][k[3:0]];
        if (elems[b] < elems[a]) a = b;
        res.idx = a;
        res.val = elems[a];
        res.err = 1'b0;
      end
      pending_min_q.push_back(res);
    end else if (kind == strm_pkg::KindClear) begin
      count = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    range_result_t exp_r;
    if (!rst_ni) begin
      count = 0;
      pending_min_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (pending_min_q.size() == 0) begin
          $display("%0t: unexpected result idx=%0d val=%0h err=%0b", $time,
                   min_index_i, min_value_i, error_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = pending_min_q.pop_front();
          if (exp_r.idx !== min_index_i || exp_r.val !== min_value_i ||
              exp_r.err !== error_i) begin
            $display("%0t: mismatch expected idx=%0d val=%0h err=%0b actual idx=%0d val=%0h err=%0b",
                     $time, exp_r.idx, exp_r.val, exp_r.err, min_index_i, min_value_i,
                     error_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (push_i && !full_i) predict_min(kind_i, value_i, left_i, right_i);
      pending_o <= pending_min_q.size();
    end
  end
endmodule

FILE: dv/sparse_table_range_min_test.sv
// Testbench top for sparse_table_range_min: drives loads, queries, clears, unused
// kinds; instantiates the block and its checker. Depends on strm_pkg and the RTL.
`timescale 1ns / 1ps

module sparse_table_range_min_test;

  logic        clk, rst_n;
  logic        push, full, empty, pop;
  logic [1:0]  kind;
  logic [31:0] value;
  logic [9:0]  left_pos, right_pos;
  logic [9:0]  min_index;
  logic [31:0] min_value;
  logic        error;
  int          fail_count, pending;
  int          send_idle_pct, recv_stall_pct;
  int unsigned shadow_count;  // loaded count as the stimulus sees it

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  sparse_table_range_min dut (
    .clk_i(clk), .rst_ni(rst_n), .push_i(push), .full_o(full),
    .kind_i(kind), .value_i(value), .left_i(left_pos), .right_i(right_pos),
    .empty_o(empty), .pop_i(pop), .min_index_o(min_index),
    .min_value_o(min_value), .error_o(error)
  );

  sparse_table_range_min_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .push_i(push), .full_i(full),
    .kind_i(kind), .value_i(value), .left_i(left_pos), .right_i(right_pos),
    .empty_i(empty), .pop_i(pop), .min_index_i(min_index),
    .min_value_i(min_value), .error_i(error),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver: stall pop at random per the current phase.
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one transaction, holding it until accepted; idle beforehand at random.
  task automatic send(logic [1:0] k, logic [31:0] v, logic [9:0] l, logic [9:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    kind <= k;
    value <= v;
    left_pos <= l;
    right_pos <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    if (k == strm_pkg::KindLoad && shadow_count < strm_pkg::MaxElements) shadow_count++;
    if (k == strm_pkg::KindClear) shadow_count = 0;
  endtask

  task automatic load_value(logic [31:0] v);
    send(strm_pkg::KindLoad, v, 10'($urandom), 10'($urandom));
  endtask

  // Query mostly inside the loaded range, sometimes past it.
  task automatic random_query();
    int unsigned lim;
    lim = (shadow_count == 0) ? 1 : shadow_count;
    if ($urandom_range(9) == 0)
      send(strm_pkg::KindQuery, $urandom, 10'($urandom_range(1023)),
           10'($urandom_range(1023)));
    else
      send(strm_pkg::KindQuery, $urandom, 10'($urandom_range(lim - 1)),
           10'($urandom_range(lim - 1)));
  endtask

  task automatic set_phase(int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    kind = strm_pkg::KindLoad;
    value = '0;
    left_pos = '0;
    right_pos = '0;
    shadow_count = 0;
    set_phase(0, 0);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty and out-of-range queries, extremes, ties, swaps, unused kind.
    send(strm_pkg::KindQuery, '0, 10'd0, 10'd0);
    load_value(32'hFFFF_FFFF);
    load_value(32'h0);
    load_value(32'h0);
    load_value(32'h5555_AAAA);
    load_value(32'hAAAA_5555);
    send(strm_pkg::KindQuery, '0, 10'd0, 10'd4);
    send(strm_pkg::KindQuery, '0, 10'd4, 10'd1);
    send(strm_pkg::KindQuery, '0, 10'd2, 10'd2);
    send(strm_pkg::KindQuery, '0, 10'd3, 10'd5);
    send(strm_pkg::KindQuery, '0, 10'd1023, 10'd1023);
    send(strm_pkg::KindUnused, 32'hFFFF_FFFF, 10'h3FF, 10'h3FF);
    send(strm_pkg::KindClear, '0, '0, '0);
    send(strm_pkg::KindQuery, '0, 10'd0, 10'd0);

    // Fill the table to capacity with random values, some repeated for ties.
    for (int i = 0; i < strm_pkg::MaxElements; i++)
      load_value(($urandom_range(3) == 0) ? 32'd7 : $urandom);
    load_value($urandom);
    send(strm_pkg::KindQuery, '0, 10'd0, 10'd1023);
    send(strm_pkg::KindQuery, '0, 10'd1023, 10'd512);
    for (int i = 0; i < 60; i++) random_query();

    // Hold until every expected result has drained.
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    // Random phases: clear, then interleave loads, queries, clears and unused kinds.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_phase(0, 0);
        1: set_phase(49, 0);
        2: set_phase(0, 49);
        default: set_phase(18, 18);
      endcase
      send(strm_pkg::KindClear, '0, '0, '0);
      for (int i = 0; i < 130; i++) begin
        case ($urandom_range(19))
          0: send(strm_pkg::KindClear, '0, '0, '0);
          1: send(strm_pkg::KindUnused, $urandom, 10'($urandom), 10'($urandom));
          2, 3, 4, 5, 6, 7, 8, 9:
            load_value(($urandom_range(4) == 0) ? $urandom_range(3) : $urandom);
          default: random_query();
        endcase
      end
    end

    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

FILE: files.f
design/strm_pkg.sv
design/strm_front.sv
design/strm_queue.sv
design/strm_back.sv
design/sparse_table_range_min.sv
dv/sparse_table_range_min_checker.sv
dv/sparse_table_range_min_test.sv
